// ----- hw/rtl/ppr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parallel printer handshake package
// Operation codes, register map, reset values and shared types.
// ----------------------------------------------------------------------------
package ppr_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_STROBE = 2'd1,
        OP_DATA   = 2'd2,
        OP_ONLINE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_ACK_LOW_DELAY      = 2'd0,
        REG_BUSY_RELEASE_DELAY = 2'd1,
        REG_ACK_RELEASE_DELAY  = 2'd2
    } reg_idx_t;

    localparam logic [7:0] ACK_LOW_DELAY_RST      = 8'd10;
    localparam logic [7:0] BUSY_RELEASE_DELAY_RST = 8'd7;
    localparam logic [7:0] ACK_RELEASE_DELAY_RST  = 8'd5;

    typedef struct packed {
        logic [7:0] ack_low_delay;
        logic [7:0] busy_release_delay;
        logic [7:0] ack_release_delay;
    } cfg_t;

    typedef struct packed {
        logic       busy_line;
        logic       ack_line;
        logic       paper_end_line;
        logic       fault_line;
        logic       print_valid;
        logic [7:0] print_byte;
    } result_t;

    function automatic logic [7:0] load_value(input logic [7:0] delay);
        return (delay == 8'd0) ? 8'd1 : delay;
    endfunction

endpackage

// ----- hw/rtl/ppr_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parallel printer handshake core
// Line state, delay counters and the result of each accepted transfer.
// ----------------------------------------------------------------------------
module ppr_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  ppr_pkg::op_t      op,
    input  logic              level,
    input  logic [7:0]        data,
    input  ppr_pkg::cfg_t     cfg,
    output ppr_pkg::result_t  res
);
    import ppr_pkg::*;

    logic       strobe_prev_reg, strobe_prev_next;
    logic       busy_reg, busy_next;
    logic       ack_reg, ack_next;
    logic       paper_fault_reg, paper_fault_next;
    logic [7:0] data_latch_reg, data_latch_next;
    logic [7:0] ack_low_count_reg, ack_low_count_next;
    logic [7:0] busy_low_count_reg, busy_low_count_next;
    logic [7:0] ack_high_count_reg, ack_high_count_next;
    logic       print_valid;
    logic [7:0] print_byte;

    always_comb
    begin
        strobe_prev_next    = strobe_prev_reg;
        busy_next           = busy_reg;
        ack_next            = ack_reg;
        paper_fault_next    = paper_fault_reg;
        data_latch_next     = data_latch_reg;
        ack_low_count_next  = ack_low_count_reg;
        busy_low_count_next = busy_low_count_reg;
        ack_high_count_next = ack_high_count_reg;
        print_valid         = 1'b0;
        print_byte          = 8'd0;
        case (op)
            OP_TICK:
            begin
                if (ack_low_count_reg != 8'd0)
                    ack_low_count_next = ack_low_count_reg - 8'd1;
                if (busy_low_count_reg != 8'd0)
                    busy_low_count_next = busy_low_count_reg - 8'd1;
                if (ack_high_count_reg != 8'd0)
                    ack_high_count_next = ack_high_count_reg - 8'd1;
                if (ack_low_count_reg == 8'd1)
                begin
                    ack_next            = 1'b0;
                    print_valid         = 1'b1;
                    print_byte          = data_latch_reg;
                    busy_low_count_next = load_value(cfg.busy_release_delay);
                end
                if (busy_low_count_reg == 8'd1)
                begin
                    busy_next           = 1'b0;
                    ack_high_count_next = load_value(cfg.ack_release_delay);
                end
                if (ack_high_count_reg == 8'd1)
                    ack_next = 1'b1;
            end
            OP_STROBE:
            begin
                if (strobe_prev_reg && !level && !busy_reg)
                begin
                    busy_next          = 1'b1;
                    ack_low_count_next = load_value(cfg.ack_low_delay);
                end
                strobe_prev_next = level;
            end
            OP_DATA:
                data_latch_next = data;
            OP_ONLINE:
            begin
                paper_fault_next = level;
                busy_next        = ~level;
            end
            default:
            begin
                busy_next = busy_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_prev_reg    <= 1'b1;
            busy_reg           <= 1'b1;
            ack_reg            <= 1'b0;
            paper_fault_reg    <= 1'b0;
            data_latch_reg     <= 8'd0;
            ack_low_count_reg  <= 8'd0;
            busy_low_count_reg <= 8'd0;
            ack_high_count_reg <= 8'd0;
        end
        else if (step)
        begin
            strobe_prev_reg    <= strobe_prev_next;
            busy_reg           <= busy_next;
            ack_reg            <= ack_next;
            paper_fault_reg    <= paper_fault_next;
            data_latch_reg     <= data_latch_next;
            ack_low_count_reg  <= ack_low_count_next;
            busy_low_count_reg <= busy_low_count_next;
            ack_high_count_reg <= ack_high_count_next;
        end
    end

    assign res.busy_line      = busy_next;
    assign res.ack_line       = ack_next;
    assign res.paper_end_line = paper_fault_next;
    assign res.fault_line     = paper_fault_next;
    assign res.print_valid    = print_valid;
    assign res.print_byte     = print_byte;

endmodule

// ----- hw/rtl/ppr_outbuf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parallel printer handshake output buffer
// Result register with a skid stage that holds one input transfer under stall.
// ----------------------------------------------------------------------------
module ppr_outbuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ppr_pkg::result_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ppr_pkg::result_t  out_data
);
    import ppr_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    push;
    logic    pop;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
                main_next = in_data;
            else
                main_valid_next = 1'b0;
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_next       = in_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = in_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

// ----- hw/rtl/parallel_printer_handshake_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parallel printer handshake top level
// Printer side of a parallel-port handshake with APB delay registers.
// Results are registered; a two-entry output buffer absorbs result stalls.
// Throughput: one transfer per cycle until that buffer is full.
// Reset: asynchronous, active low; BUSY high, ACK low, counters idle, delays
// at 10, 7 and 5 ticks.
// ----------------------------------------------------------------------------
module parallel_printer_handshake_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic        line_level,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        busy_line,
    output logic        ack_line,
    output logic        paper_end_line,
    output logic        fault_line,
    output logic        print_valid,
    output logic [7:0]  print_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ppr_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    result_t  core_res;
    result_t  out_res;
    reg_idx_t reg_idx;
    logic     cfg_wr;
    logic     step;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_ACK_LOW_DELAY:      cfg_next.ack_low_delay      = pwdata[7:0];
                REG_BUSY_RELEASE_DELAY: cfg_next.busy_release_delay = pwdata[7:0];
                REG_ACK_RELEASE_DELAY:  cfg_next.ack_release_delay  = pwdata[7:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ACK_LOW_DELAY:      prdata = {24'd0, cfg_reg.ack_low_delay};
            REG_BUSY_RELEASE_DELAY: prdata = {24'd0, cfg_reg.busy_release_delay};
            REG_ACK_RELEASE_DELAY:  prdata = {24'd0, cfg_reg.ack_release_delay};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ack_low_delay      <= ACK_LOW_DELAY_RST;
            cfg_reg.busy_release_delay <= BUSY_RELEASE_DELAY_RST;
            cfg_reg.ack_release_delay  <= ACK_RELEASE_DELAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign step = in_valid && in_ready;

    ppr_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .op    (op_t'(operation)),
        .level (line_level),
        .data  (data_byte),
        .cfg   (cfg_reg),
        .res   (core_res)
    );

    ppr_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (core_res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_res)
    );

    assign busy_line      = out_res.busy_line;
    assign ack_line       = out_res.ack_line;
    assign paper_end_line = out_res.paper_end_line;
    assign fault_line     = out_res.fault_line;
    assign print_valid    = out_res.print_valid;
    assign print_byte     = out_res.print_byte;

endmodule

// ----- tb/ppr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parallel printer handshake checker
// Watches the item, result and register ports of the printer handshake,
// keeps its own copy of the printer lines, the delay counters and the delay
// registers, and compares every result transfer field by field with the
// oldest predicted status. Mapped register reads are checked against the copy.
// ----------------------------------------------------------------------------
module ppr_checker
    import ppr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  operation,
    input  logic        line_level,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        busy_line,
    input  logic        ack_line,
    input  logic        paper_end_line,
    input  logic        fault_line,
    input  logic        print_valid,
    input  logic [7:0]  print_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);

    cfg_t       delays;
    logic       strobe_seen;
    logic       busy;
    logic       ack;
    logic       online;
    logic [7:0] bus_latch;
    logic [7:0] ack_fall_cnt;
    logic [7:0] busy_fall_cnt;
    logic [7:0] ack_rise_cnt;

    result_t    status_due[$];
    result_t    seen;
    result_t    want;
    logic [7:0] held;
    logic       mapped;

    function automatic result_t next_status(input op_t op, input logic lvl,
                                            input logic [7:0] b);
        result_t r;
        logic    fell_ack;
        logic    fell_busy;
        logic    rose_ack;
        r = '0;
        case (op)
            OP_TICK:
            begin
                fell_ack  = (ack_fall_cnt == 8'd1);
                fell_busy = (busy_fall_cnt == 8'd1);
                rose_ack  = (ack_rise_cnt == 8'd1);
                if (ack_fall_cnt != 8'd0)
                    ack_fall_cnt = ack_fall_cnt - 8'd1;
                if (busy_fall_cnt != 8'd0)
                    busy_fall_cnt = busy_fall_cnt - 8'd1;
                if (ack_rise_cnt != 8'd0)
                    ack_rise_cnt = ack_rise_cnt - 8'd1;
                if (fell_ack)
                begin
                    ack = 1'b0;
                    r.print_valid = 1'b1;
                    r.print_byte = bus_latch;
                    busy_fall_cnt = (delays.busy_release_delay == 8'd0) ? 8'd1
                                                                        : delays.busy_release_delay;
                end
                if (fell_busy)
                begin
                    busy = 1'b0;
                    ack_rise_cnt = (delays.ack_release_delay == 8'd0) ? 8'd1
                                                                      : delays.ack_release_delay;
                end
                if (rose_ack)
                    ack = 1'b1;
            end
            OP_STROBE:
            begin
                if (strobe_seen && !lvl && !busy)
                begin
                    busy = 1'b1;
                    ack_fall_cnt = (delays.ack_low_delay == 8'd0) ? 8'd1
                                                                  : delays.ack_low_delay;
                end
                strobe_seen = lvl;
            end
            OP_DATA:
                bus_latch = b;
            default:
            begin
                online = lvl;
                busy = ~lvl;
            end
        endcase
        r.busy_line = busy;
        r.ack_line = ack;
        r.paper_end_line = online;
        r.fault_line = online;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp,
                               input logic [31:0] act);
        if (act !== exp)
        begin
            errors++;
            $display("%0t ppr_checker: %s expected %0d, got %0d", $time, name, exp, act);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delays = {ACK_LOW_DELAY_RST, BUSY_RELEASE_DELAY_RST, ACK_RELEASE_DELAY_RST};
            strobe_seen = 1'b1;
            busy = 1'b1;
            ack = 1'b0;
            online = 1'b0;
            bus_latch = 8'd0;
            ack_fall_cnt = 8'd0;
            busy_fall_cnt = 8'd0;
            ack_rise_cnt = 8'd0;
            status_due.delete();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen = {busy_line, ack_line, paper_end_line, fault_line,
                        print_valid, print_byte};
                if (status_due.size() == 0)
                begin
                    errors++;
                    $display("%0t ppr_checker: result %h with none expected", $time, seen);
                end
                else
                begin
                    want = status_due.pop_front();
                    check_field("busy_line", 32'(want.busy_line), 32'(seen.busy_line));
                    check_field("ack_line", 32'(want.ack_line), 32'(seen.ack_line));
                    check_field("paper_end_line", 32'(want.paper_end_line),
                                32'(seen.paper_end_line));
                    check_field("fault_line", 32'(want.fault_line), 32'(seen.fault_line));
                    check_field("print_valid", 32'(want.print_valid), 32'(seen.print_valid));
                    check_field("print_byte", 32'(want.print_byte), 32'(seen.print_byte));
                end
            end
            if (in_valid && in_ready)
                status_due.push_back(next_status(op_t'(operation), line_level, data_byte));
            if (psel && penable && pready)
            begin
                mapped = 1'b1;
                case (reg_idx_t'(paddr[3:2]))
                    REG_ACK_LOW_DELAY:      held = delays.ack_low_delay;
                    REG_BUSY_RELEASE_DELAY: held = delays.busy_release_delay;
                    REG_ACK_RELEASE_DELAY:  held = delays.ack_release_delay;
                    default:                mapped = 1'b0;
                endcase
                if (!pwrite && mapped)
                    check_field("prdata", {24'd0, held}, prdata);
                if (pwrite)
                begin
                    case (reg_idx_t'(paddr[3:2]))
                        REG_ACK_LOW_DELAY:      delays.ack_low_delay = pwdata[7:0];
                        REG_BUSY_RELEASE_DELAY: delays.busy_release_delay = pwdata[7:0];
                        REG_ACK_RELEASE_DELAY:  delays.ack_release_delay = pwdata[7:0];
                        default:                ;
                    endcase
                end
            end
            pending <= status_due.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parallel printer handshake testbench
// Drives line, data and tick items into the printer handshake with random
// gaps and result stalls, steps the delay registers through several settings
// including zero and full scale, and leaves all checking to the checker.
// ----------------------------------------------------------------------------
module tb;
    import ppr_pkg::*;

    localparam logic [1:0] UNMAPPED_IDX = 2'd3;
    localparam int         STALL_LIMIT  = 5000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic        line_level;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        busy_line;
    logic        ack_line;
    logic        paper_end_line;
    logic        fault_line;
    logic        print_valid;
    logic [7:0]  print_byte;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic        calm = 1'b0;
    int          errors;
    int          pending;
    int          sent = 0;
    int          quiet = 0;

    always #2 clk = ~clk;

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 34);

    parallel_printer_handshake_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .line_level(line_level), .data_byte(data_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .busy_line(busy_line), .ack_line(ack_line),
        .paper_end_line(paper_end_line), .fault_line(fault_line),
        .print_valid(print_valid), .print_byte(print_byte),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ppr_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .line_level(line_level), .data_byte(data_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .busy_line(busy_line), .ack_line(ack_line),
        .paper_end_line(paper_end_line), .fault_line(fault_line),
        .print_valid(print_valid), .print_byte(print_byte),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .errors(errors), .pending(pending)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet <= 0;
        else if (quiet == STALL_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic logic [3:0] reg_addr(input reg_idx_t r);
        return {r, 2'b00};
    endfunction

    task automatic send(input op_t op, input logic lvl, input logic [7:0] b);
        logic taken;
        while (!calm && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        line_level <= lvl;
        data_byte <= b;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [3:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_delays(input logic [7:0] ack_low, input logic [7:0] busy_rel,
                              input logic [7:0] ack_rel);
        apb_access(1'b1, reg_addr(REG_ACK_LOW_DELAY), {24'($urandom), ack_low});
        apb_access(1'b1, reg_addr(REG_BUSY_RELEASE_DELAY), {24'($urandom), busy_rel});
        apb_access(1'b1, reg_addr(REG_ACK_RELEASE_DELAY), {24'($urandom), ack_rel});
        apb_access(1'b0, reg_addr(REG_ACK_LOW_DELAY), 32'd0);
        apb_access(1'b0, reg_addr(REG_BUSY_RELEASE_DELAY), 32'd0);
        apb_access(1'b0, reg_addr(REG_ACK_RELEASE_DELAY), 32'd0);
    endtask

    task automatic print_job(input int max_ticks);
        if ($urandom_range(1))
            send(OP_ONLINE, 1'b1, 8'($urandom_range(255)));
        send(OP_DATA, 1'($urandom_range(1)), 8'($urandom_range(255)));
        send(OP_STROBE, 1'b1, 8'($urandom_range(255)));
        send(OP_STROBE, 1'b0, 8'($urandom_range(255)));
        repeat ($urandom_range(max_ticks))
            send(OP_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    task automatic random_traffic(input int count, input int max_ticks);
        int   start;
        logic paused;
        start = sent;
        paused = 1'b0;
        while (sent - start < count)
        begin
            if (!paused && sent - start >= count / 2)
            begin
                settle();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 70)
                print_job(max_ticks);
            else
                repeat ($urandom_range(1, 4))
                    send(op_t'($urandom_range(3)), 1'($urandom_range(1)),
                         8'($urandom_range(255)));
        end
        settle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_TICK;
        line_level = 1'b0;
        data_byte = 8'd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 4'd0;
        pwdata = 32'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_access(1'b1, {UNMAPPED_IDX, 2'b00}, $urandom);
        set_delays(8'd1, 8'd0, 8'd2);

        send(OP_TICK, 1'b0, 8'h00);
        send(OP_STROBE, 1'b0, 8'h00);
        send(OP_STROBE, 1'b1, 8'hFF);
        send(OP_ONLINE, 1'b1, 8'h00);
        send(OP_DATA, 1'b0, 8'hFF);
        send(OP_STROBE, 1'b0, 8'h00);
        send(OP_DATA, 1'b1, 8'h00);
        send(OP_TICK, 1'b1, 8'hFF);
        send(OP_ONLINE, 1'b1, 8'h00);
        send(OP_STROBE, 1'b1, 8'h00);
        send(OP_STROBE, 1'b0, 8'h00);
        send(OP_TICK, 1'b0, 8'h00);
        send(OP_TICK, 1'b0, 8'h00);
        send(OP_TICK, 1'b0, 8'h00);
        send(OP_TICK, 1'b0, 8'h00);
        send(OP_ONLINE, 1'b0, 8'h00);
        send(OP_DATA, 1'b0, 8'hA5);
        send(OP_ONLINE, 1'b1, 8'h00);
        send(OP_STROBE, 1'b1, 8'h00);
        send(OP_STROBE, 1'b0, 8'h00);
        send(OP_STROBE, 1'b1, 8'h00);
        send(OP_ONLINE, 1'b1, 8'h00);
        send(OP_STROBE, 1'b0, 8'h00);
        send(OP_ONLINE, 1'b0, 8'h00);
        send(OP_TICK, 1'b0, 8'h00);
        send(OP_TICK, 1'b0, 8'h00);
        send(OP_TICK, 1'b0, 8'h00);
        settle();

        set_delays(8'd1, 8'd1, 8'd1);
        random_traffic(30, 6);

        calm <= 1'b1;
        set_delays(8'd3, 8'd2, 8'd4);
        random_traffic(30, 14);
        calm <= 1'b0;

        set_delays(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
                   8'($urandom_range(1, 8)));
        random_traffic(30, 26);

        set_delays(8'd0, 8'd5, 8'd0);
        random_traffic(20, 8);

        set_delays(8'd255, 8'd1, 8'd1);
        send(OP_ONLINE, 1'b1, 8'($urandom_range(255)));
        send(OP_DATA, 1'b0, 8'h5A);
        send(OP_STROBE, 1'b1, 8'($urandom_range(255)));
        send(OP_STROBE, 1'b0, 8'($urandom_range(255)));
        repeat (255 + 4)
            send(OP_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)));
        settle();

        set_delays(ACK_LOW_DELAY_RST, BUSY_RELEASE_DELAY_RST, ACK_RELEASE_DELAY_RST);
        random_traffic(20, 30);

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/ppr_pkg.sv
hw/rtl/ppr_core.sv
hw/rtl/ppr_outbuf.sv
hw/rtl/parallel_printer_handshake_top.sv
tb/ppr_checker.sv
tb/tb.sv
